/* hw/rtl/tsac_pkg.sv */
// Shared types and constants for the touch sample averaging and calibration block.
package tsac_pkg;

  // Field and register widths
  localparam int WORD_W   = 16;
  localparam int COEF_W   = 40;
  localparam int SIZE_W   = 32;
  localparam int CFG_IDX_W = 3;

  // Default number of position samples averaged per touch
  localparam int TSAC_SAMPLES = 16;

  // Pressure detection
  localparam int              PRESS_SHIFT     = 3;
  localparam logic [WORD_W-1:0] Z_OFFSET      = 16'd4095;
  localparam logic [WORD_W-1:0] PRESS_THRESHOLD = 16'd300;

  // Fixed-point format of the calibration coefficients
  localparam int COEF_FRAC_BITS = 24;
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(64'd1 << COEF_FRAC_BITS);

  // Product and accumulator widths (coefficient times 16-bit unsigned mean)
  localparam int PROD_W = COEF_W + WORD_W + 1;
  localparam int ACC_W  = PROD_W + 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_C      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_D      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_E      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_F      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_SIZE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION    = 3'd7;

  localparam logic [SIZE_W-1:0] SCREEN_SIZE_RST = 32'd15728960;

  // Opcodes of the input request
  localparam logic OP_PRESSURE = 1'b0;
  localparam logic OP_POSITION = 1'b1;

  // Display rotation
  typedef enum logic [1:0] {
    ROT_0,
    ROT_90,
    ROT_180,
    ROT_270
  } tsac_rot_t;

  // Load enables of the calibration pipeline stages
  typedef struct packed {
    logic prod;
    logic sum;
  } tsac_stage_en_t;

endpackage

/* hw/rtl/tsac_affine.sv */
// One axis of the affine calibration: two products, offset, rounding, saturation.
module tsac_affine import tsac_pkg::*; (
  input  logic                     clk,
  input  tsac_stage_en_t           en,
  input  logic        [WORD_W-1:0] mean_x,
  input  logic        [WORD_W-1:0] mean_y,
  input  logic signed [COEF_W-1:0] gain_x,
  input  logic signed [COEF_W-1:0] gain_y,
  input  logic signed [COEF_W-1:0] offset,
  output logic        [WORD_W-1:0] result
);

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (COEF_FRAC_BITS - 1));

  logic signed [PROD_W-1:0] prod_x_r;
  logic signed [PROD_W-1:0] prod_y_r;
  logic signed [ACC_W-1:0]  acc;
  logic        [WORD_W-1:0] sat_nxt;
  logic        [WORD_W-1:0] result_r;

  // Product stage: signed coefficient times unsigned mean, operands at full product width
  always_ff @(posedge clk) begin
    if (en.prod) begin
      prod_x_r <= PROD_W'(gain_x) * PROD_W'($signed({1'b0, mean_x}));
      prod_y_r <= PROD_W'(gain_y) * PROD_W'($signed({1'b0, mean_y}));
    end
  end

  // Sum, round half up, clamp to 0..65535
  always_comb begin
    acc = ACC_W'(prod_x_r) + ACC_W'(prod_y_r) + ACC_W'(offset) + ROUND_HALF;
    if (acc[ACC_W-1]) begin
      sat_nxt = '0;
    end else if (|acc[ACC_W-2:COEF_FRAC_BITS+WORD_W]) begin
      sat_nxt = '1;
    end else begin
      sat_nxt = acc[COEF_FRAC_BITS +: WORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum) begin
      result_r <= sat_nxt;
    end
  end

  assign result = result_r;

endmodule

/* hw/rtl/touch_sample_average_calibrate.sv */
// Top level: pressure detection, sample averaging, affine calibration and rotation.
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  input    | in_valid in_ready in_opcode in_word_a/b | request in
//  result   | out_valid out_ready out_touched         | request out
//           | out_screen_x out_screen_y               |
//  config   | cfg_wr_en cfg_index cfg_wdata           | write only
//
// One input request is taken every cycle while in_ready is high; pressure and position requests update
// the collection state in the cycle they are accepted.
// A result passes through five register stages after its request is accepted:
// rounded sum, mean (shift or reciprocal multiply), products, saturation,
// rotation.
// Reset (rst_n low at a clock edge) empties the pipeline, stops any collection
// and loads the register defaults. Stalls on out_ready fill empty stages first;
// in_ready drops only when every stage holds a result.
module touch_sample_average_calibrate import tsac_pkg::*; #(
  parameter int SAMPLES = TSAC_SAMPLES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_opcode,
  input  logic [WORD_W-1:0]    in_word_a,
  input  logic [WORD_W-1:0]    in_word_b,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_touched,
  output logic [WORD_W-1:0]    out_screen_x,
  output logic [WORD_W-1:0]    out_screen_y,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_wdata
);

  localparam int CNT_W = $clog2(SAMPLES);
  localparam int SUM_W = WORD_W + CNT_W;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES - 1);
  localparam logic [SUM_W-1:0] HALF     = SUM_W'(SAMPLES / 2);
  localparam bit POW2 = ((SAMPLES & (SAMPLES - 1)) == 0);

  // Configuration registers
  logic signed [COEF_W-1:0] coef_a_r, coef_b_r, coef_c_r;
  logic signed [COEF_W-1:0] coef_d_r, coef_e_r, coef_f_r;
  logic [SIZE_W-1:0]        screen_size_r;
  tsac_rot_t                rotation_r;

  // Collection state
  logic             collecting_r, collecting_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_x_r, sum_x_nxt;
  logic [SUM_W-1:0] sum_y_r, sum_y_nxt;

  // Pipeline
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic t1_r, t2_r, t3_r, t4_r;
  logic rdy2, rdy3, rdy4, rdy5;
  logic [SUM_W-1:0]  nx1_r, ny1_r, nx1_nxt, ny1_nxt;
  logic [WORD_W-1:0] mean_x, mean_y;
  logic [WORD_W-1:0] mx2_r, my2_r;
  logic [WORD_W-1:0] sx4, sy4;
  logic [WORD_W-1:0] ox_nxt, oy_nxt;
  logic              touched_r;
  logic [WORD_W-1:0] screen_x_r, screen_y_r;

  logic              accept;
  logic              push, push_touched;
  logic [WORD_W-1:0] z;
  tsac_stage_en_t    aff_en;

  // Ready chain: a stage loads when empty or when it drains downstream
  assign rdy5     = !out_valid_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign in_ready = !v1_r || rdy2;
  assign accept   = in_valid && in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r      <= COEF_ONE;
      coef_b_r      <= '0;
      coef_c_r      <= '0;
      coef_d_r      <= '0;
      coef_e_r      <= COEF_ONE;
      coef_f_r      <= '0;
      screen_size_r <= SCREEN_SIZE_RST;
      rotation_r    <= ROT_0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_COEF_A:      coef_a_r      <= cfg_wdata;
        CFG_COEF_B:      coef_b_r      <= cfg_wdata;
        CFG_COEF_C:      coef_c_r      <= cfg_wdata;
        CFG_COEF_D:      coef_d_r      <= cfg_wdata;
        CFG_COEF_E:      coef_e_r      <= cfg_wdata;
        CFG_COEF_F:      coef_f_r      <= cfg_wdata;
        CFG_SCREEN_SIZE: screen_size_r <= cfg_wdata[SIZE_W-1:0];
        CFG_ROTATION:    rotation_r    <= tsac_rot_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  // Pressure value: z1/8 + 4095 - z2/8, wrapping at 16 bits
  assign z = WORD_W'(in_word_a >> PRESS_SHIFT) + Z_OFFSET - WORD_W'(in_word_b >> PRESS_SHIFT);

  // Collection state update and result push
  always_comb begin
    collecting_nxt = collecting_r;
    cnt_nxt        = cnt_r;
    sum_x_nxt      = sum_x_r;
    sum_y_nxt      = sum_y_r;
    push           = 1'b0;
    push_touched   = 1'b0;
    nx1_nxt        = sum_x_r + SUM_W'(in_word_b) + HALF;
    ny1_nxt        = sum_y_r + SUM_W'(in_word_a) + HALF;
    if (in_opcode == OP_PRESSURE) begin
      // any pressure request restarts; low pressure reports no touch
      cnt_nxt   = '0;
      sum_x_nxt = '0;
      sum_y_nxt = '0;
      if (z < PRESS_THRESHOLD) begin
        collecting_nxt = 1'b0;
        push           = 1'b1;
      end else begin
        collecting_nxt = 1'b1;
      end
    end else if (collecting_r) begin
      if (cnt_r == LAST_CNT) begin
        collecting_nxt = 1'b0;
        cnt_nxt        = '0;
        sum_x_nxt      = '0;
        sum_y_nxt      = '0;
        push           = 1'b1;
        push_touched   = 1'b1;
      end else begin
        cnt_nxt   = cnt_r + 1'b1;
        sum_x_nxt = sum_x_r + SUM_W'(in_word_b);
        sum_y_nxt = sum_y_r + SUM_W'(in_word_a);
      end
    end
  end

  // Mean: divide the rounded sum by the sample count
  generate
    if (POW2) begin : g_shift
      assign mean_x = nx1_r[CNT_W +: WORD_W];
      assign mean_y = ny1_r[CNT_W +: WORD_W];
    end else begin : g_recip
      // floor(n / SAMPLES) = (n * ceil(2^K / SAMPLES)) >> K for n below 2^SUM_W
      localparam int DIV_K = SUM_W + CNT_W;
      localparam int RCP_W = SUM_W + 1;
      localparam longint unsigned RECIP_L = ((64'd1 << DIV_K) + SAMPLES - 1) / SAMPLES;
      localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_L);
      logic [SUM_W+RCP_W-1:0] qx, qy;
      assign qx     = (SUM_W+RCP_W)'(nx1_r) * (SUM_W+RCP_W)'(RECIP);
      assign qy     = (SUM_W+RCP_W)'(ny1_r) * (SUM_W+RCP_W)'(RECIP);
      assign mean_x = qx[DIV_K +: WORD_W];
      assign mean_y = qy[DIV_K +: WORD_W];
    end
  endgenerate

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      cnt_r        <= '0;
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        collecting_r <= collecting_nxt;
        cnt_r        <= cnt_nxt;
        sum_x_r      <= sum_x_nxt;
        sum_y_r      <= sum_y_nxt;
      end
      if (in_ready) v1_r <= accept && push;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) out_valid_r <= v4_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (in_ready) begin
      t1_r  <= push_touched;
      nx1_r <= nx1_nxt;
      ny1_r <= ny1_nxt;
    end
    if (rdy2) begin
      t2_r  <= t1_r;
      mx2_r <= mean_x;
      my2_r <= mean_y;
    end
    if (rdy3) t3_r <= t2_r;
    if (rdy4) t4_r <= t3_r;
    if (rdy5) begin
      touched_r  <= t4_r;
      screen_x_r <= t4_r ? ox_nxt : '0;
      screen_y_r <= t4_r ? oy_nxt : '0;
    end
  end

  // Affine calibration for both axes
  assign aff_en.prod = rdy3;
  assign aff_en.sum  = rdy4;

  tsac_affine u_aff_x (
    .clk    (clk),
    .en     (aff_en),
    .mean_x (mx2_r),
    .mean_y (my2_r),
    .gain_x (coef_a_r),
    .gain_y (coef_b_r),
    .offset (coef_c_r),
    .result (sx4)
  );

  tsac_affine u_aff_y (
    .clk    (clk),
    .en     (aff_en),
    .mean_x (mx2_r),
    .mean_y (my2_r),
    .gain_x (coef_d_r),
    .gain_y (coef_e_r),
    .offset (coef_f_r),
    .result (sy4)
  );

  // Display rotation, subtractions wrap at 16 bits
  always_comb begin
    case (rotation_r)
      ROT_0: begin
        ox_nxt = sx4;
        oy_nxt = sy4;
      end
      ROT_90: begin
        ox_nxt = sy4;
        oy_nxt = screen_size_r[SIZE_W-1:WORD_W] - sx4;
      end
      ROT_180: begin
        ox_nxt = screen_size_r[WORD_W-1:0] - sx4;
        oy_nxt = screen_size_r[SIZE_W-1:WORD_W] - sy4;
      end
      default: begin
        ox_nxt = screen_size_r[WORD_W-1:0] - sy4;
        oy_nxt = sx4;
      end
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_touched  = touched_r;
  assign out_screen_x = screen_x_r;
  assign out_screen_y = screen_y_r;

endmodule

/* hw/rtl/tsac_checker.sv */
// Port-level assertions for the touch calibration block, bound to the top level.
module tsac_checker import tsac_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_touched,
  input logic [WORD_W-1:0] out_screen_x,
  input logic [WORD_W-1:0] out_screen_y
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_touched)
      && $stable(out_screen_x) && $stable(out_screen_y))
    else $error("stalled result changed");

  // No-touch results carry zero coordinates
  a_untouched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_touched |-> out_screen_x == '0 && out_screen_y == '0)
    else $error("untouched result with nonzero coordinates");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // With no result pending the pipeline has room for a new request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output empty");

endmodule

bind touch_sample_average_calibrate tsac_checker u_tsac_checker (.*);
